@@ rtl/core/lts_pkg.sv @@
// Shared sizes and controller/datapath interface types for the LRU tag store.
`timescale 1ns / 1ps
`default_nettype none
package lts_pkg;

  localparam int ENTRIES    = 8;
  localparam int KEY_BITS   = 64;
  localparam int STAMP_BITS = 32;

  localparam int KEY_PORT_BITS = 64;
  localparam int SIZE_BITS     = 17;
  localparam int SLOT_BITS     = 3;
  localparam int IDX_BITS      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // One stored entry: {stamp, size, key}.
  localparam int ENTRY_BITS = STAMP_BITS + SIZE_BITS + KEY_BITS;
  localparam int KEY_LSB    = 0;
  localparam int SIZE_LSB   = KEY_BITS;
  localparam int STAMP_LSB  = KEY_BITS + SIZE_BITS;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef logic [IDX_BITS-1:0] idx_t;

  typedef struct packed {
    logic load;     // capture the incoming word and bump the visit counter
    logic rd_en;    // read one entry for the scan
    idx_t rd_addr;
    logic write;    // commit the entry update and present the result
  } lts_cmd_t;

  typedef struct packed {
    logic any_free; // at least one slot is still invalid
  } lts_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/lts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/lts_ctrl.sv @@
// Sequencer that steps the datapath through load, entry scan and commit.
`timescale 1ns / 1ps
`default_nettype none
module lts_ctrl import lts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_mode,
  input  wire lts_sts_t sts,
  output      lts_cmd_t cmd,
  output      logic     busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  localparam idx_t LAST_IDX = IDX_BITS'(ENTRIES - 1);

  logic [1:0] state_r, state_nxt;
  idx_t       scan_r, scan_nxt;

  always_comb begin
    state_nxt   = state_r;
    scan_nxt    = scan_r;
    cmd.load    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = scan_r;
    cmd.write   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        scan_nxt = '0;
        if (start) begin
          cmd.load = 1'b1;
          // An insert with a free slot needs no scan of the stamps.
          if (in_mode == MODE_INSERT && sts.any_free) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/lts_dp.sv @@
// Datapath: entry store, valid bits, visit counter, scan compare and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lts_dp import lts_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lts_cmd_t                 cmd,
  input  wire logic                     in_mode,
  input  wire logic [KEY_PORT_BITS-1:0] in_key,
  input  wire logic [SIZE_BITS-1:0]     in_size,
  output      lts_sts_t                 sts,
  output      logic                     out_valid,
  output      logic                     out_hit,
  output      logic [SLOT_BITS-1:0]     out_slot,
  output      logic [SIZE_BITS-1:0]     out_stored_size,
  output      logic                     out_evicted
);

  logic [ENTRIES-1:0]    valid_r;
  logic [STAMP_BITS-1:0] cnt_r;
  logic                  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [SIZE_BITS-1:0]  size_r;

  logic                  cmp_vld_r;
  idx_t                  cmp_idx_r;
  logic                  found_r;
  idx_t                  hit_idx_r;
  logic [SIZE_BITS-1:0]  hit_size_r;
  logic [STAMP_BITS-1:0] best_r;
  idx_t                  best_idx_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [SLOT_BITS-1:0]  out_slot_r;
  logic [SIZE_BITS-1:0]  out_stored_size_r;
  logic                  out_evicted_r;

  logic [ENTRY_BITS-1:0] rd_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [SIZE_BITS-1:0]  rd_size;
  logic [STAMP_BITS-1:0] rd_stamp;

  idx_t                  free_idx;
  logic                  any_free;
  idx_t                  wr_idx;
  logic                  wr_en;
  logic [ENTRY_BITS-1:0] wr_data;

  lts_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  assign rd_key   = rd_data[KEY_LSB +: KEY_BITS];
  assign rd_size  = rd_data[SIZE_LSB +: SIZE_BITS];
  assign rd_stamp = rd_data[STAMP_LSB +: STAMP_BITS];

  // Lowest-index invalid slot.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign any_free     = ~&valid_r;
  assign sts.any_free = any_free;

  // A lookup rewrites the hit entry with its own key and size and the new stamp.
  always_comb begin
    if (mode_r == MODE_INSERT) begin
      wr_idx  = any_free ? free_idx : best_idx_r;
      wr_en   = cmd.write;
      wr_data = {cnt_r, size_r, key_r};
    end else begin
      wr_idx  = hit_idx_r;
      wr_en   = cmd.write && found_r;
      wr_data = {cnt_r, hit_size_r, key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r   <= cmd.rd_en;
      out_valid_r <= cmd.write;
      if (cmd.load && cnt_r != '1) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.rd_addr;
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key[KEY_BITS-1:0];
      size_r  <= in_size;
      found_r <= 1'b0;
    end
    if (cmp_vld_r) begin
      if (!found_r && valid_r[cmp_idx_r] && rd_key == key_r) begin
        found_r    <= 1'b1;
        hit_idx_r  <= cmp_idx_r;
        hit_size_r <= rd_size;
      end
      // Strict compare keeps the lowest index among equal stamps.
      if (cmp_idx_r == '0 || rd_stamp < best_r) begin
        best_r     <= rd_stamp;
        best_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.write) begin
      if (mode_r == MODE_INSERT) begin
        out_hit_r         <= 1'b0;
        out_slot_r        <= SLOT_BITS'(wr_idx);
        out_stored_size_r <= '0;
        out_evicted_r     <= !any_free;
      end else begin
        out_hit_r         <= found_r;
        out_slot_r        <= found_r ? SLOT_BITS'(hit_idx_r) : '0;
        out_stored_size_r <= found_r ? hit_size_r : '0;
        out_evicted_r     <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_stored_size = out_stored_size_r;
  assign out_evicted     = out_evicted_r;

endmodule
`default_nettype wire

@@ rtl/core/lru_tag_store_core.sv @@
// Top level of the fully associative LRU tag store.
// Usage:
//   Input word: in_mode (0 lookup, 1 insert), in_key and in_size. A word is
//   taken at a rising edge where start is high and busy is low.
//   Result word: out_hit, out_slot, out_stored_size and out_evicted, shown for
//   exactly one cycle while out_valid is high. Every input word yields one result.
//   Each word bumps a saturating visit counter that stamps the touched entry.
//   A lookup or an insert into a full store scans all ENTRIES entries through
//   the single read port of the entry RAM, one entry per cycle, then passes
//   the drain and write states before out_valid is registered high.
//   An insert while a free slot exists skips the scan and goes straight to
//   the write state, from which out_valid is registered high.
//   busy drops in the cycle the result is shown, so the next word can be
//   taken at the edge that ends it; one word is in flight at a time.
//   The receiver cannot stall: each result must be taken in its single cycle.
//   Reset (rst_n low, synchronous) clears the valid bits, the visit counter
//   and the sequencer; entry contents are left as they are and are never
//   used before being written.
`timescale 1ns / 1ps
`default_nettype none
module lru_tag_store_core import lts_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic                     in_mode,
  input  wire logic [KEY_PORT_BITS-1:0] in_key,
  input  wire logic [SIZE_BITS-1:0]     in_size,
  output      logic                     out_valid,
  output      logic                     out_hit,
  output      logic [SLOT_BITS-1:0]     out_slot,
  output      logic [SIZE_BITS-1:0]     out_stored_size,
  output      logic                     out_evicted
);

  lts_cmd_t cmd;
  lts_sts_t sts;

  lts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  lts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_size         (in_size),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_stored_size (out_stored_size),
    .out_evicted     (out_evicted)
  );

  // An accepted word always moves the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result is never shown in two consecutive cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A result is only shown while no other word is being worked on.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while sequencer busy");

  // Hit and eviction belong to different operations.
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("result reports both hit and eviction");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the LRU tag store core: predicts each result word.
`timescale 1ns / 1ps
module tb;
  import lts_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 1000;
  localparam int POOL_KEYS    = 12;
  localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = 17'd102400;

  typedef struct {
    logic                     mode;
    logic [KEY_PORT_BITS-1:0] key;
    logic [SIZE_BITS-1:0]     size;
    bit                       drain_first;
  } tag_req_t;

  typedef struct {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic [SIZE_BITS-1:0] stored_size;
    logic                 evicted;
  } tag_resp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     in_mode = MODE_LOOKUP;
  logic [KEY_PORT_BITS-1:0] in_key = '0;
  logic [SIZE_BITS-1:0]     in_size = '0;
  logic                     busy;
  logic                     out_valid;
  logic                     out_hit;
  logic [SLOT_BITS-1:0]     out_slot;
  logic [SIZE_BITS-1:0]     out_stored_size;
  logic                     out_evicted;

  lru_tag_store_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_key(in_key),
    .in_size(in_size),
    .out_valid(out_valid),
    .out_hit(out_hit),
    .out_slot(out_slot),
    .out_stored_size(out_stored_size),
    .out_evicted(out_evicted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the tag store.
  logic                  store_valid [ENTRIES];
  logic [KEY_BITS-1:0]   store_key   [ENTRIES];
  logic [SIZE_BITS-1:0]  store_size  [ENTRIES];
  logic [STAMP_BITS-1:0] store_stamp [ENTRIES];
  logic [STAMP_BITS-1:0] visit_count = '0;

  tag_req_t  req_q[$];
  tag_resp_t resp_expect_q[$];
  tag_req_t  cur_req;

  int n_lookup = 0, n_hit = 0, n_insert = 0, n_evict = 0;
  int n_fail = 0;
  int cycle_cnt = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      store_valid[i] = 1'b0;
      store_key[i]   = '0;
      store_size[i]  = '0;
      store_stamp[i] = '0;
    end
  end

  function automatic tag_resp_t predict_tag_access(tag_req_t req);
    tag_resp_t             r;
    logic [KEY_BITS-1:0]   k;
    logic [STAMP_BITS-1:0] best;
    int                    target;
    bit                    found;
    r.hit = 1'b0;
    r.slot = '0;
    r.stored_size = '0;
    r.evicted = 1'b0;
    k = req.key[KEY_BITS-1:0];
    found = 1'b0;
    target = 0;
    if (visit_count != '1) visit_count++;
    if (req.mode == MODE_LOOKUP) begin
      n_lookup++;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && store_valid[i] && store_key[i] == k) begin
          found = 1'b1;
          store_stamp[i] = visit_count;
          r.hit = 1'b1;
          r.slot = SLOT_BITS'(i);
          r.stored_size = store_size[i];
        end
      end
      if (found) n_hit++;
    end else begin
      n_insert++;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && !store_valid[i]) begin
          found = 1'b1;
          target = i;
        end
      end
      if (!found) begin
        // Strict compare keeps the lowest index among equal stamps.
        best = store_stamp[0];
        for (int i = 1; i < ENTRIES; i++) begin
          if (store_stamp[i] < best) begin
            best = store_stamp[i];
            target = i;
          end
        end
        r.evicted = 1'b1;
        n_evict++;
      end
      store_valid[target] = 1'b1;
      store_key[target]   = k;
      store_size[target]  = req.size;
      store_stamp[target] = visit_count;
      r.slot = SLOT_BITS'(target);
    end
    return r;
  endfunction

  // Driver: bursts of words separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  int drv_accepted = 0;
  int drv_seen = 0;

  always @(posedge clk) begin
    bit taking;
    taking = start && !busy;
    if (rst_n) begin
      if (out_valid) drv_seen++;
      if (taking) begin
        resp_expect_q.push_back(predict_tag_access(cur_req));
        drv_accepted++;
      end
      if (!start || taking) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() == 0 ||
                     (req_q[0].drain_first && drv_accepted != drv_seen)) begin
          start <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          start   <= 1'b1;
          in_mode <= cur_req.mode;
          in_key  <= cur_req.key;
          in_size <= cur_req.size;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest prediction.
  always @(posedge clk) begin
    tag_resp_t exp_resp;
    if (rst_n && out_valid) begin
      if (resp_expect_q.size() == 0) begin
        $error("unexpected result word: hit %0h slot %0h size %0h evicted %0h",
               out_hit, out_slot, out_stored_size, out_evicted);
        n_fail++;
      end else begin
        exp_resp = resp_expect_q.pop_front();
        if (out_hit !== exp_resp.hit) begin
          $error("hit expected %0h actual %0h", exp_resp.hit, out_hit);
          n_fail++;
        end
        if (out_slot !== exp_resp.slot) begin
          $error("slot expected %0h actual %0h", exp_resp.slot, out_slot);
          n_fail++;
        end
        if (out_stored_size !== exp_resp.stored_size) begin
          $error("stored_size expected %0h actual %0h",
                 exp_resp.stored_size, out_stored_size);
          n_fail++;
        end
        if (out_evicted !== exp_resp.evicted) begin
          $error("evicted expected %0h actual %0h", exp_resp.evicted, out_evicted);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("lru_tag_store_core: mismatch");
      $finish;
    end
  end

  task automatic queue_word(logic mode, logic [KEY_PORT_BITS-1:0] key,
                            logic [SIZE_BITS-1:0] size, bit drain_first = 1'b0);
    tag_req_t req;
    req.mode = mode;
    req.key = key;
    req.size = size;
    req.drain_first = drain_first;
    req_q.push_back(req);
  endtask

  initial begin
    logic [KEY_PORT_BITS-1:0] key_pool [POOL_KEYS];
    logic [KEY_PORT_BITS-1:0] k;
    logic [SIZE_BITS-1:0]     sz;
    int                       pick;

    // Directed part: extremes, duplicate keys, hits, misses and eviction order.
    queue_word(MODE_LOOKUP, '0, '0);
    queue_word(MODE_INSERT, '0, '0);
    queue_word(MODE_INSERT, '1, '1);
    queue_word(MODE_INSERT, 64'h8000_0000_0000_0000, SIZE_LIMIT);
    queue_word(MODE_INSERT, 64'd1, SIZE_LIMIT + 17'd1);
    queue_word(MODE_INSERT, 64'd1, 17'd77);
    queue_word(MODE_INSERT, 64'h5555_5555_5555_5555, 17'h0AAAA);
    queue_word(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 17'h15555);
    queue_word(MODE_INSERT, 64'h0123_4567_89AB_CDEF, 17'd1);
    queue_word(MODE_LOOKUP, 64'd1, '1, 1'b1);
    queue_word(MODE_LOOKUP, '1, '0);
    queue_word(MODE_LOOKUP, '0, 17'd5);
    queue_word(MODE_LOOKUP, 64'd5, '0);
    queue_word(MODE_INSERT, 64'd5, 17'd500);
    queue_word(MODE_INSERT, 64'd6, 17'd600);
    queue_word(MODE_LOOKUP, 64'h8000_0000_0000_0000, '0);
    queue_word(MODE_LOOKUP, 64'd1, '0);
    queue_word(MODE_INSERT, 64'd7, 17'd700);
    queue_word(MODE_LOOKUP, 64'd5, '1);
    queue_word(MODE_LOOKUP, 64'h0123_4567_89AB_CDEE, '0);

    // Random part: mostly reuse of a small key pool so hits and evictions occur.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 200 == 0) begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      if (pick >= 90) k = {$urandom, $urandom};
      else if (pick >= 80) k = k ^ (64'd1 << $urandom_range(0, 63));
      sz = ($urandom_range(0, 9) == 0) ? SIZE_BITS'($urandom_range(0, 17'h1FFFF))
                                       : SIZE_BITS'($urandom_range(0, SIZE_LIMIT));
      queue_word($urandom_range(0, 1) ? MODE_INSERT : MODE_LOOKUP, k, sz,
                 (n % 150 == 75));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (req_q.size() != 0 || start || resp_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d lookups (%0d hits) and %0d inserts (%0d evictions)",
             n_lookup, n_hit, n_insert, n_evict);
    $display("sender ran in random bursts and gaps, with idle drains in between");
    if (n_fail == 0 && resp_expect_q.size() == 0) begin
      $display("lru_tag_store_core: match");
    end else begin
      $display("lru_tag_store_core: mismatch");
    end
    $finish;
  end

endmodule
